// File: rtl/core/matrix_multiply_core_defines.svh
// Assertion macros for the matrix multiply core.
// Defining NO_ASSERTIONS leaves every macro empty.
`ifndef MATRIX_MULTIPLY_CORE_DEFINES_SVH
`define MATRIX_MULTIPLY_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define MMC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MMC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define MMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: rtl/core/mmc_pkg.sv
// Shared constants, types and arithmetic helpers of the matrix multiply core.
// No dependencies.
package mmc_pkg;

    localparam int MAX_DIM   = 8;
    localparam int FRAC_BITS = 16;

    localparam int DIM_CAP     = (MAX_DIM < 8) ? MAX_DIM : 8;
    localparam int IDX_W       = (DIM_CAP > 1) ? $clog2(DIM_CAP) : 1;
    localparam int DEPTH       = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int FIELD_IDX_W = 3;
    localparam int ELEM_W      = 32;
    localparam int CFG_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CMD_W       = 2;
    localparam int PROD_W      = 2 * ELEM_W;
    // full-precision terms plus growth for DIM_CAP terms and rounding margin
    localparam int ACC_W       = PROD_W + IDX_W + 1;

    typedef logic        [IDX_W-1:0]       t_idx;
    typedef logic        [ADDR_W-1:0]      t_addr;
    typedef logic        [FIELD_IDX_W-1:0] t_field_idx;
    typedef logic        [CFG_W-1:0]       t_cfg;
    typedef logic        [CFG_IDX_W-1:0]   t_cfg_idx;
    typedef logic        [CMD_W-1:0]       t_cmd;
    typedef logic signed [ELEM_W-1:0]      t_elem;
    typedef logic signed [PROD_W-1:0]      t_prod;
    typedef logic signed [ACC_W-1:0]       t_acc;

    localparam t_cmd CMD_LOAD_A  = 2'd0;
    localparam t_cmd CMD_LOAD_B  = 2'd1;
    localparam t_cmd CMD_COMPUTE = 2'd2;

    localparam t_cfg_idx REG_ROWS_A    = 2'd0;
    localparam t_cfg_idx REG_INNER_DIM = 2'd1;
    localparam t_cfg_idx REG_COLS_B    = 2'd2;

    localparam t_cfg CFG_RESET = t_cfg'(8);

    localparam t_acc ROUND_BIAS = (t_acc'(1) <<< FRAC_BITS) >>> 1;
    localparam t_acc SAT_MAX    = (t_acc'(1) <<< (ELEM_W - 1)) - t_acc'(1);
    localparam t_acc SAT_MIN    = -(t_acc'(1) <<< (ELEM_W - 1));

    // Last loop index for a dimension register: zero counts as one,
    // anything above the cap is clamped.
    function automatic t_idx dim_last(t_cfg v);
        if (v == '0) begin
            return '0;
        end else if (int'(v) > DIM_CAP) begin
            return t_idx'(DIM_CAP - 1);
        end
        return t_idx'(v - 1'b1);
    endfunction

    // Round half up to FRAC_BITS fraction bits, then clamp to the element range.
    function automatic t_elem round_sat(t_acc acc);
        t_acc rnd;
        rnd = (acc + ROUND_BIAS) >>> FRAC_BITS;
        if (rnd > SAT_MAX) begin
            return t_elem'(SAT_MAX);
        end else if (rnd < SAT_MIN) begin
            return t_elem'(SAT_MIN);
        end
        return t_elem'(rnd);
    endfunction

endpackage

// File: rtl/core/matrix_multiply_core.sv
// Matrix multiply core: C = A x B, signed Q16.16, one shared 32x32 multiplier.
// Loads: one transfer per cycle while not busy, busy stays low. Compute: each product element
// takes one A/B RAM read per term, then multiply, accumulate and round; the next element is
// issued only once the previous sum is complete.
// Results strobe one cycle each, row-major, last on the final one; they cannot be held off.
// Reset (i_rst_n, sync, active low) sets dimensions to 8; RAMs keep contents. Uses mmc_pkg.
`include "matrix_multiply_core_defines.svh"

module matrix_multiply_core import mmc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // command channel
    input  logic       start,
    output logic       busy,
    input  t_cmd       i_command,
    input  t_field_idx i_elem_row,
    input  t_field_idx i_elem_col,
    input  t_elem      i_elem_value,
    // configuration write port
    input  logic       i_cfg_we,
    input  t_cfg_idx   i_cfg_idx,
    input  t_cfg       i_cfg_data,
    // result channel
    output logic       o_strobe,
    output t_field_idx o_out_row,
    output t_field_idx o_out_col,
    output t_elem      o_out_value,
    output logic       o_last
);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;  // waiting for a command
    localparam logic [1:0] ST_ISSUE = 2'd1;  // one RAM read pair per term
    localparam logic [1:0] ST_WAIT  = 2'd2;  // drain multiply/accumulate, emit

    // control state
    logic [1:0] r_state,  n_state;
    t_cfg       r_rows_a, r_inner_dim, r_cols_b;
    t_idx       r_i, n_i;
    t_idx       r_j, n_j;
    t_idx       r_k, n_k;
    t_idx       r_last_i, n_last_i;
    t_idx       r_last_j, n_last_j;
    t_idx       r_last_k, n_last_k;
    logic       r_rd_vld,  n_rd_vld;
    logic       r_rd_last, n_rd_last;
    logic       r_mul_vld;
    logic       r_mul_last;
    logic       r_fin;
    logic       r_strobe;

    // datapath
    t_prod      r_prod;
    t_acc       r_acc;
    t_field_idx r_out_row;
    t_field_idx r_out_col;
    t_elem      r_out_value;
    logic       r_out_last;

    logic       accept;
    logic       in_store;
    logic       we_a, we_b;
    logic       last_elem;
    logic       acc_clr;
    t_addr      waddr, raddr_a, raddr_b;
    logic [ELEM_W-1:0] rdata_a, rdata_b;

    // ---------------------------------------------------------------
    // Command decode: a transfer happens on start while not busy.
    // ---------------------------------------------------------------
    assign accept   = start && !busy;
    assign busy     = (r_state != ST_IDLE);
    assign in_store = (int'(i_elem_row) < MAX_DIM) && (int'(i_elem_col) < MAX_DIM);
    assign we_a     = accept && (i_command == CMD_LOAD_A) && in_store;
    assign we_b     = accept && (i_command == CMD_LOAD_B) && in_store;
    assign waddr    = t_addr'(i_elem_row) * t_addr'(MAX_DIM) + t_addr'(i_elem_col);

    // element (r,c) lives at r*MAX_DIM+c; A walks a row, B walks a column
    assign raddr_a  = t_addr'(r_i) * t_addr'(MAX_DIM) + t_addr'(r_k);
    assign raddr_b  = t_addr'(r_k) * t_addr'(MAX_DIM) + t_addr'(r_j);

    mmc_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (i_elem_value),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    mmc_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (i_elem_value),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    // ---------------------------------------------------------------
    // Sequencer: i/j walk the product, k walks the inner dimension.
    // ---------------------------------------------------------------
    assign last_elem = (r_i == r_last_i) && (r_j == r_last_j);

    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_last_i  = r_last_i;
        n_last_j  = r_last_j;
        n_last_k  = r_last_k;
        n_rd_vld  = 1'b0;
        n_rd_last = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_command == CMD_COMPUTE)) begin
                    n_state  = ST_ISSUE;
                    n_i      = '0;
                    n_j      = '0;
                    n_k      = '0;
                    n_last_i = dim_last(r_rows_a);
                    n_last_j = dim_last(r_cols_b);
                    n_last_k = dim_last(r_inner_dim);
                end
            end
            ST_ISSUE: begin
                n_rd_vld  = 1'b1;
                n_rd_last = (r_k == r_last_k);
                if (r_k == r_last_k) begin
                    n_k     = '0;
                    n_state = ST_WAIT;
                end else begin
                    n_k = t_idx'(r_k + 1'b1);
                end
            end
            ST_WAIT: begin
                // r_fin: accumulator holds the finished sum, pipeline is empty
                if (r_fin) begin
                    if (last_elem) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_ISSUE;
                        if (r_j == r_last_j) begin
                            n_j = '0;
                            n_i = t_idx'(r_i + 1'b1);
                        end else begin
                            n_j = t_idx'(r_j + 1'b1);
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rows_a    <= CFG_RESET;
            r_inner_dim <= CFG_RESET;
            r_cols_b    <= CFG_RESET;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_last_i    <= '0;
            r_last_j    <= '0;
            r_last_k    <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_last   <= 1'b0;
            r_mul_vld   <= 1'b0;
            r_mul_last  <= 1'b0;
            r_fin       <= 1'b0;
            r_strobe    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_i        <= n_i;
            r_j        <= n_j;
            r_k        <= n_k;
            r_last_i   <= n_last_i;
            r_last_j   <= n_last_j;
            r_last_k   <= n_last_k;
            r_rd_vld   <= n_rd_vld;
            r_rd_last  <= n_rd_last;
            r_mul_vld  <= r_rd_vld;
            r_mul_last <= r_rd_last;
            r_fin      <= r_mul_vld && r_mul_last;
            r_strobe   <= r_fin;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ROWS_A:    r_rows_a    <= i_cfg_data;
                    REG_INNER_DIM: r_inner_dim <= i_cfg_data;
                    REG_COLS_B:    r_cols_b    <= i_cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------
    // Datapath: read -> multiply -> accumulate -> round/saturate.
    // ---------------------------------------------------------------
    assign acc_clr = (accept && (i_command == CMD_COMPUTE)) || r_fin;

    always_ff @(posedge i_clk) begin
        r_prod <= t_prod'(signed'(rdata_a)) * t_prod'(signed'(rdata_b));
        if (acc_clr) begin
            r_acc <= '0;
        end else if (r_mul_vld) begin
            r_acc <= r_acc + t_acc'(r_prod);
        end
        if (r_fin) begin
            r_out_row   <= t_field_idx'(r_i);
            r_out_col   <= t_field_idx'(r_j);
            r_out_value <= round_sat(r_acc);
            r_out_last  <= last_elem;
        end
    end

    assign o_strobe    = r_strobe;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_out_value = r_out_value;
    assign o_last      = r_out_last;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `MMC_ASSERT_NOW(a_last_ends_run, i_clk, i_rst_n, o_strobe && o_last, !busy,
        "last result strobed while the sequencer is still running")
    `MMC_ASSERT_NEXT(a_compute_goes_busy, i_clk, i_rst_n,
        start && !busy && (i_command == CMD_COMPUTE), busy,
        "compute command taken but sequencer did not start")
    `MMC_ASSERT_NOW(a_pipe_only_busy, i_clk, i_rst_n, r_rd_vld || r_mul_vld || r_fin, busy,
        "multiply pipeline active while idle")

endmodule

// File: rtl/core/mmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
